[design/composite_palette_to_rgb_defines.svh]
// Assertion macros for the composite palette to RGB block.
// Used by composite_palette_to_rgb.sv; expects i_clk and i_rst_n in scope.
`ifndef COMPOSITE_PALETTE_TO_RGB_DEFINES_SVH
`define COMPOSITE_PALETTE_TO_RGB_DEFINES_SVH

`ifndef SYNTH
// Consequent must hold in the cycle after the antecedent
`define CPR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pipeline check failed");
// Consequent must hold in the same cycle as the antecedent
`define CPR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pipeline check failed");
`else
`define CPR_ASSERT_NEXT(lbl, ante, cons)
`define CPR_ASSERT_NOW(lbl, ante, cons)
`endif

`endif

[design/cpr_pkg.sv]
// Shared constants, types and elaboration-time helpers for the palette block.
// No dependencies; imported by composite_palette_to_rgb.
package cpr_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int IDX_W         = 9;
    localparam int CH_W          = 16;
    localparam int NPH           = 12;

    // Magnitude codes of the cosine table
    localparam logic [1:0] MAG_ZERO = 2'd0;
    localparam logic [1:0] MAG_HALF = 2'd1;
    localparam logic [1:0] MAG_S    = 2'd2;
    localparam logic [1:0] MAG_ONE  = 2'd3;

    // Selectors for the per-level product tables
    localparam int TAB_V = 0;
    localparam int TAB_S = 1;
    localparam int TAB_H = 2;

    // Sixteen entries, one per {attenuate, level index}
    typedef logic [15:0][63:0] t_tab;

    // Signal levels in thousandths: dim table then bright table
    localparam int LEVEL_MILLI [8] = '{350, 518, 962, 1550, 1094, 1506, 1962, 1962};

    // Round a fraction in millionths to fixed point, ties away from zero
    function automatic longint fix_micro(longint micro, int frac);
        longint num;
        num = micro <<< frac;
        if (num >= 0) return (num + 500000) / 1000000;
        return -((-num + 500000) / 1000000);
    endfunction

    // Round a fraction in billionths to fixed point, ties away from zero
    function automatic longint fix_nano(longint nano, int frac);
        longint num;
        num = nano <<< frac;
        if (num >= 0) return (num + 500000000) / 1000000000;
        return -((-num + 500000000) / 1000000000);
    endfunction

    // Fixed-point product with rounding, ties away from zero
    function automatic longint mul_round(longint a, longint b, int frac);
        longint n;
        longint h;
        n = a * b;
        h = 64'sd1 <<< (frac - 1);
        if (n >= 0) return (n + h) >>> frac;
        return -((-n + h) >>> frac);
    endfunction

    // Normalised phase value between black and white, divided by twelve
    function automatic longint phase_fix(int lidx, int att, int frac);
        longint spot;
        longint num;
        spot = longint'(LEVEL_MILLI[lidx]) * ((att != 0) ? 746 : 1000);
        num  = (spot - 518000) <<< frac;
        if (num >= 0) return (num + 8664000) / 17328000;
        return -((-num + 8664000) / 17328000);
    endfunction

    // Build a table of phase values, optionally scaled by s or one half
    function automatic t_tab make_tab(int which, int frac);
        t_tab   t;
        longint v;
        longint e;
        for (int k = 0; k < 16; k++) begin
            v = phase_fix(k & 7, k >> 3, frac);
            case (which)
                TAB_S:   e = mul_round(v, fix_nano(866025404, frac), frac);
                TAB_H:   e = mul_round(v, 64'sd1 <<< (frac - 1), frac);
                default: e = v;
            endcase
            t[k] = e;
        end
        return t;
    endfunction

    // Cosine of a phase as {negative, magnitude code}
    function automatic logic [2:0] cos_kind(int ph);
        logic [2:0] r;
        case (ph)
            0:       r = {1'b0, MAG_ONE};
            1:       r = {1'b0, MAG_S};
            2:       r = {1'b0, MAG_HALF};
            3:       r = {1'b0, MAG_ZERO};
            4:       r = {1'b1, MAG_HALF};
            5:       r = {1'b1, MAG_S};
            6:       r = {1'b1, MAG_ONE};
            7:       r = {1'b1, MAG_S};
            8:       r = {1'b1, MAG_HALF};
            9:       r = {1'b0, MAG_ZERO};
            10:      r = {1'b0, MAG_HALF};
            11:      r = {1'b0, MAG_S};
            default: r = {1'b0, MAG_ZERO};
        endcase
        return r;
    endfunction

endpackage

[design/composite_palette_to_rgb.sv]
// An accepted color index passes through eight register stages to its RGB result:
// decode, table lookup, two add tree levels, chroma scaling, multiply, rounding, clamp.
// Throughput: one transaction per cycle while the receiver does not stall.
// Stall passes back through full stages only, so bubbles are filled before o_stall rises.
// Reset (synchronous, active low) clears the stage valid bits; payload is not reset.
// Depends on cpr_pkg and composite_palette_to_rgb_defines.svh.
`include "composite_palette_to_rgb_defines.svh"

module composite_palette_to_rgb #(
    parameter int FRAC_BITS = cpr_pkg::FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [cpr_pkg::IDX_W-1:0] i_color_index,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [cpr_pkg::CH_W-1:0] o_red,
    output logic [cpr_pkg::CH_W-1:0] o_green,
    output logic [cpr_pkg::CH_W-1:0] o_blue
);
    import cpr_pkg::*;

    localparam int W    = FRAC_BITS + 5;
    localparam int NSTG = 8;
    localparam int NGRP = NPH / 4;

    typedef logic signed [W-1:0]      t_val;
    typedef logic signed [2*W-1:0]    t_prod;
    typedef logic [W+CH_W-1:0]        t_scl;
    typedef logic [3:0]               t_code;

    localparam t_tab VTAB = make_tab(TAB_V, FRAC_BITS);
    localparam t_tab STAB = make_tab(TAB_S, FRAC_BITS);
    localparam t_tab HTAB = make_tab(TAB_H, FRAC_BITS);

    // YIQ to RGB matrix
    localparam t_val KRI = t_val'(fix_micro(946882, FRAC_BITS));
    localparam t_val KRQ = t_val'(fix_micro(623557, FRAC_BITS));
    localparam t_val KGI = t_val'(fix_micro(-274788, FRAC_BITS));
    localparam t_val KGQ = t_val'(fix_micro(-635691, FRAC_BITS));
    localparam t_val KBI = t_val'(fix_micro(-1108545, FRAC_BITS));
    localparam t_val KBQ = t_val'(fix_micro(1709007, FRAC_BITS));

    localparam t_prod PRD_HALF = t_prod'(1) <<< (FRAC_BITS - 1);
    localparam t_scl  SCL_HALF = t_scl'(1) << (FRAC_BITS - 1);
    localparam t_scl  SCL_MAX  = t_scl'({CH_W{1'b1}});

    // Residue mod 12 of a value below 36
    function automatic logic [3:0] mod12(logic [5:0] x);
        logic [5:0] r;
        if (x >= 6'd24)      r = x - 6'd24;
        else if (x >= 6'd12) r = x - 6'd12;
        else                 r = x;
        return r[3:0];
    endfunction

    // Phase value times a cosine entry
    function automatic t_val pick(t_code code, logic [2:0] kind);
        t_val m;
        case (kind[1:0])
            MAG_ONE:  m = t_val'(VTAB[code]);
            MAG_S:    m = t_val'(STAB[code]);
            MAG_HALF: m = t_val'(HTAB[code]);
            default:  m = '0;
        endcase
        return kind[2] ? -m : m;
    endfunction

    // Drop the fraction of a product, ties away from zero
    function automatic t_val rnd_prod(t_prod p);
        t_prod s;
        s = p + PRD_HALF - t_prod'(p[2*W-1]);
        return t_val'(s >>> FRAC_BITS);
    endfunction

    // Clamp a channel to 0..1 and scale to the output range
    function automatic logic [CH_W-1:0] to_channel(t_val c);
        t_scl m;
        t_scl r;
        logic [CH_W-1:0] o;
        m = (t_scl'(c[W-2:0]) << CH_W) - t_scl'(c[W-2:0]);
        r = (m + SCL_HALF) >> FRAC_BITS;
        if (c <= t_val'(0))   o = '0;
        else if (r > SCL_MAX) o = {CH_W{1'b1}};
        else                  o = r[CH_W-1:0];
        return o;
    endfunction

    // Stage valid bits and load enables
    logic [NSTG-1:0] r_vld;
    logic [NSTG:0]   w_rdy;

    // Stage registers
    t_code r_code [NPH];
    t_val  r_ty [NPH];
    t_val  r_ti [NPH];
    t_val  r_tq [NPH];
    t_val  r_py [NGRP];
    t_val  r_pi [NGRP];
    t_val  r_pq [NGRP];
    t_val  r_y3, r_i3, r_q3;
    t_val  r_y4, r_i4, r_q4;
    t_val  r_y5;
    t_prod r_prd [6];
    t_val  r_ch [3];
    logic [CH_W-1:0] r_red, r_green, r_blue;

    // Next values
    t_code n_code [NPH];
    t_val  n_ty [NPH];
    t_val  n_ti [NPH];
    t_val  n_tq [NPH];
    t_val  n_py [NGRP];
    t_val  n_pi [NGRP];
    t_val  n_pq [NGRP];
    t_val  n_y3, n_i3, n_q3;
    t_val  n_i4, n_q4;
    t_prod n_prd [6];
    t_val  n_ch [3];

    // Propagate readiness back through full stages; an empty stage is always ready
    always_comb begin
        w_rdy[NSTG] = !i_stall;
        for (int k = NSTG - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign o_stall = !w_rdy[0];
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < NSTG; k++) begin
                if (w_rdy[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Stage 0: decode hue, level and emphasis into a level code per phase
    logic [3:0] w_hue;
    logic [1:0] w_lvl;
    logic [2:0] w_lo_idx, w_hi_idx;

    assign w_hue    = i_color_index[3:0];
    assign w_lvl    = (w_hue < 4'd14) ? i_color_index[5:4] : 2'd1;
    assign w_lo_idx = {w_hue == 4'd0, w_lvl};
    assign w_hi_idx = {w_hue < 4'd13, w_lvl};

    for (genvar p = 0; p < NPH; p++) begin : g_ph
        localparam bit         EM_R = ((p + 20) % 12) < 6;
        localparam bit         EM_G = ((p + 12) % 12) < 6;
        localparam bit         EM_B = ((p + 16) % 12) < 6;
        localparam logic [5:0] OFS  = 6'(p + 8);
        localparam logic [2:0] KC   = cos_kind(p);
        localparam logic [2:0] KS   = cos_kind((p + 9) % 12);
        logic w_hi;
        logic w_att;

        assign w_hi  = mod12({2'b00, w_hue} + OFS) < 4'd6;
        assign w_att = (i_color_index[6] & EM_R) | (i_color_index[7] & EM_G)
                     | (i_color_index[8] & EM_B);
        assign n_code[p] = {w_att, w_hi ? w_hi_idx : w_lo_idx};

        // Stage 1: look up Y, I and Q terms of this phase
        assign n_ty[p] = t_val'(VTAB[r_code[p]]);
        assign n_ti[p] = pick(r_code[p], KC);
        assign n_tq[p] = pick(r_code[p], KS);
    end

    // Stage 2 and 3: sum the twelve terms in groups of four, then the groups
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_py[g] = r_ty[4*g] + r_ty[4*g+1] + r_ty[4*g+2] + r_ty[4*g+3];
            n_pi[g] = r_ti[4*g] + r_ti[4*g+1] + r_ti[4*g+2] + r_ti[4*g+3];
            n_pq[g] = r_tq[4*g] + r_tq[4*g+1] + r_tq[4*g+2] + r_tq[4*g+3];
        end
        n_y3 = '0;
        n_i3 = '0;
        n_q3 = '0;
        for (int g = 0; g < NGRP; g++) begin
            n_y3 = n_y3 + r_py[g];
            n_i3 = n_i3 + r_pi[g];
            n_q3 = n_q3 + r_pq[g];
        end
    end

    // Stage 4: scale chroma by 1.5, rounding half away from zero
    always_comb begin
        t_val w_i;
        t_val w_q;
        w_i  = r_i3 + (r_i3 <<< 1);
        w_q  = r_q3 + (r_q3 <<< 1);
        n_i4 = (w_i + t_val'(!w_i[W-1])) >>> 1;
        n_q4 = (w_q + t_val'(!w_q[W-1])) >>> 1;
    end

    // Stage 5: matrix products
    always_comb begin
        n_prd[0] = t_prod'(KRI) * t_prod'(r_i4);
        n_prd[1] = t_prod'(KRQ) * t_prod'(r_q4);
        n_prd[2] = t_prod'(KGI) * t_prod'(r_i4);
        n_prd[3] = t_prod'(KGQ) * t_prod'(r_q4);
        n_prd[4] = t_prod'(KBI) * t_prod'(r_i4);
        n_prd[5] = t_prod'(KBQ) * t_prod'(r_q4);
    end

    // Stage 6: round products and add luma
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_ch[c] = r_y5 + rnd_prod(r_prd[2*c]) + rnd_prod(r_prd[2*c+1]);
        end
    end

    // Advance payload where the stage takes a new transaction
    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) r_code <= n_code;
        if (w_rdy[1]) begin
            r_ty <= n_ty;
            r_ti <= n_ti;
            r_tq <= n_tq;
        end
        if (w_rdy[2]) begin
            r_py <= n_py;
            r_pi <= n_pi;
            r_pq <= n_pq;
        end
        if (w_rdy[3]) begin
            r_y3 <= n_y3;
            r_i3 <= n_i3;
            r_q3 <= n_q3;
        end
        if (w_rdy[4]) begin
            r_y4 <= r_y3;
            r_i4 <= n_i4;
            r_q4 <= n_q4;
        end
        if (w_rdy[5]) begin
            r_y5  <= r_y4;
            r_prd <= n_prd;
        end
        if (w_rdy[6]) r_ch <= n_ch;
        if (w_rdy[7]) begin
            r_red   <= to_channel(r_ch[0]);
            r_green <= to_channel(r_ch[1]);
            r_blue  <= to_channel(r_ch[2]);
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

    // Pipeline control checks
    `CPR_ASSERT_NEXT(a_accept_loads, i_valid && !o_stall, r_vld[0])
    `CPR_ASSERT_NOW(a_stall_only_full, o_stall, &r_vld)
    `CPR_ASSERT_NEXT(a_drain_moves, r_vld[NSTG-2] && !i_stall, r_vld[NSTG-1])

endmodule

[test/palette_rgb_checker.sv]
// Checker for composite_palette_to_rgb: predicts each RGB result from the colour index
// and compares it with what leaves the block. Depends on cpr_pkg for widths.
module palette_rgb_checker #(
    parameter int FRAC = cpr_pkg::FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic [cpr_pkg::IDX_W-1:0] i_color_index,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic [cpr_pkg::CH_W-1:0]  i_red,
    input  logic [cpr_pkg::CH_W-1:0]  i_green,
    input  logic [cpr_pkg::CH_W-1:0]  i_blue,
    output int                        o_fail_count,
    output int                        o_pending
);

    typedef logic [cpr_pkg::CH_W-1:0] t_chan;

    typedef struct {
        logic [cpr_pkg::IDX_W-1:0] index;
        t_chan                     red;
        t_chan                     green;
        t_chan                     blue;
    } t_rgb;

    localparam longint UNITY    = 64'sd1 <<< FRAC;
    localparam longint CHAN_MAX = (64'sd1 <<< cpr_pkg::CH_W) - 1;

    // Composite voltage levels in thousandths: dim set, then bright set
    localparam int DAC_MILLI [8] = '{350, 518, 962, 1550, 1094, 1506, 1962, 1962};

    t_rgb rgb_pending[$];
    int   mismatches = 0;

    // Divide with rounding to nearest, ties away from zero (d > 0)
    function automatic longint div_nearest(longint n, longint d);
        if (n >= 0) return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function automatic longint to_fixed(longint num, longint den);
        return div_nearest(num <<< FRAC, den);
    endfunction

    function automatic longint fixed_mul(longint a, longint b);
        return div_nearest(a * b, UNITY);
    endfunction

    // Square wave of the colour carrier: high for six of the twelve phases
    function automatic bit carrier_high(int ph, int hue);
        return ((hue + ph + 8) % 12) < 6;
    endfunction

    function automatic t_chan clamp_channel(longint v);
        longint r;
        if (v <= 0) return '0;
        r = div_nearest(v * CHAN_MAX, UNITY);
        if (r > CHAN_MAX) r = CHAN_MAX;
        return t_chan'(r);
    endfunction

    // Simulate twelve composite phases, decode YIQ and convert to RGB
    function automatic t_rgb predict_rgb(logic [cpr_pkg::IDX_W-1:0] idx);
        int     hue;
        int     lvl;
        int     lo;
        int     hi;
        bit     atten;
        longint spot;
        longint v;
        longint luma;
        longint ci;
        longint cq;
        longint s;
        longint half;
        longint cos_tab [12];
        t_rgb   res;
        hue  = int'(idx[3:0]);
        lvl  = (hue < 14) ? int'(idx[5:4]) : 1;
        lo   = DAC_MILLI[lvl + ((hue == 0) ? 4 : 0)];
        hi   = DAC_MILLI[lvl + ((hue < 13) ? 4 : 0)];
        s    = to_fixed(866025404, 1000000000);
        half = to_fixed(1, 2);
        cos_tab = '{UNITY, s, half, 0, -half, -s, -UNITY, -s, -half, 0, half, s};
        luma = 0;
        ci   = 0;
        cq   = 0;
        for (int ph = 0; ph < 12; ph++) begin
            spot  = carrier_high(ph, hue) ? hi : lo;
            atten = (idx[6] && carrier_high(ph, 12)) || (idx[7] && carrier_high(ph, 4))
                 || (idx[8] && carrier_high(ph, 8));
            spot  = spot * (atten ? 746 : 1000);
            v     = to_fixed(spot - 518000, 17328000);
            luma += v;
            ci   += fixed_mul(v, cos_tab[ph]);
            cq   += fixed_mul(v, cos_tab[(ph + 9) % 12]);
        end
        // Saturation of one and a half
        ci = div_nearest(ci * 3, 2);
        cq = div_nearest(cq * 3, 2);
        res.index = idx;
        res.red   = clamp_channel(luma + fixed_mul(to_fixed(946882, 1000000), ci)
                                       + fixed_mul(to_fixed(623557, 1000000), cq));
        res.green = clamp_channel(luma + fixed_mul(to_fixed(-274788, 1000000), ci)
                                       + fixed_mul(to_fixed(-635691, 1000000), cq));
        res.blue  = clamp_channel(luma + fixed_mul(to_fixed(-1108545, 1000000), ci)
                                       + fixed_mul(to_fixed(1709007, 1000000), cq));
        return res;
    endfunction

    // Queue a prediction per input transaction, compare per output transaction
    always @(posedge i_clk) begin : watch_channels
        t_rgb want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall)
                rgb_pending.push_back(predict_rgb(i_color_index));
            if (i_out_valid && !i_out_stall) begin
                if (rgb_pending.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result: r=%04h g=%04h b=%04h",
                                 i_red, i_green, i_blue);
                    mismatches++;
                end else begin
                    want = rgb_pending.pop_front();
                    if (want.red !== i_red || want.green !== i_green
                            || want.blue !== i_blue) begin
                        if (mismatches < 10)
                            $display("mismatch idx %03h exp %04h %04h %04h got %04h %04h %04h",
                                     want.index, want.red, want.green, want.blue,
                                     i_red, i_green, i_blue);
                        mismatches++;
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= rgb_pending.size();
    end

endmodule

[test/testbench.sv]
// Top of the palette testbench: clock, reset, stimulus, receiver stalls and verdict.
// Depends on composite_palette_to_rgb, cpr_pkg and palette_rgb_checker.
module testbench;

    localparam int RANDOM_COUNT   = 1900;
    localparam int PRESSURE_HOLD  = 300;
    localparam int DRAIN_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT = 3000;

    // Extremes and the hue/level special cases
    localparam logic [cpr_pkg::IDX_W-1:0] SPECIAL_INDEX [7] =
        '{9'h000, 9'h1FF, 9'h03E, 9'h00F, 9'h02D, 9'h1C0, 9'h030};
    localparam int DIRECTED_COUNT = 16 + 7;

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_valid       = 1'b0;
    logic [cpr_pkg::IDX_W-1:0] i_color_index = '0;
    logic                      i_stall       = 1'b0;
    logic                      o_stall;
    logic                      o_valid;
    logic [cpr_pkg::CH_W-1:0]  o_red;
    logic [cpr_pkg::CH_W-1:0]  o_green;
    logic [cpr_pkg::CH_W-1:0]  o_blue;

    int fail_count;
    int pending_count;
    int indices_sent  = 0;
    int idle_cycles   = 0;
    bit pressure_done = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    composite_palette_to_rgb i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_color_index (i_color_index),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue)
    );

    palette_rgb_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_color_index (i_color_index),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_red         (o_red),
        .i_green       (o_green),
        .i_blue        (o_blue),
        .o_fail_count  (fail_count),
        .o_pending     (pending_count)
    );

    // Offer one colour index and hold it until the block takes it
    task automatic offer_index(logic [cpr_pkg::IDX_W-1:0] idx);
        i_valid       <= 1'b1;
        i_color_index <= idx;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Stimulus: directed indices, then random ones with random gaps
    initial begin : drive_indices
        logic [cpr_pkg::IDX_W-1:0] idx;
        int r;
        int gap;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int n = 0; n < DIRECTED_COUNT + RANDOM_COUNT; n++) begin
            // Walk every hue once first, with level and emphasis taken from its index bits
            if (n < 16)
                idx = {n[2:0], n[3:2], n[3:0]};
            else if (n < DIRECTED_COUNT)
                idx = SPECIAL_INDEX[n - 16];
            else
                idx = cpr_pkg::IDX_W'($urandom_range(0, 511));
            offer_index(idx);
            indices_sent++;
            r = $urandom_range(0, 99);
            if (((n / 150) % 4) == 3 || r < 55)
                gap = 0;
            else if (r < 85)
                gap = $urandom_range(1, 3);
            else if (r < 97)
                gap = $urandom_range(4, 12);
            else
                gap = $urandom_range(20, 60);
            if (gap > 0) begin
                i_valid       <= 1'b0;
                i_color_index <= cpr_pkg::IDX_W'($urandom_range(0, 511));
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;
        // Drain: wait for every prediction to be matched, then settle
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Receiver: random stalls, one long hold-off to back the pipeline up
    initial begin : drive_stall
        int r;
        int hold;
        @(posedge i_clk);
        forever begin
            r = $urandom_range(0, 99);
            if (!pressure_done && indices_sent >= 400) begin
                hold          = PRESSURE_HOLD;
                pressure_done = 1'b1;
            end else if (((indices_sent / 200) % 3) == 2 || r < 50)
                hold = 0;
            else if (r < 85)
                hold = $urandom_range(1, 3);
            else if (r < 97)
                hold = $urandom_range(4, 12);
            else
                hold = $urandom_range(20, 40);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    // Watchdog: abort when no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

[composite_palette_to_rgb.f]
+incdir+design
design/cpr_pkg.sv
design/composite_palette_to_rgb.sv
test/palette_rgb_checker.sv
test/testbench.sv
